// ----- hdl/atd_pkg.sv -----
// ----------------------------------------------------------------------------
// atd_pkg
// Shared types and fixed constants of the atan2 degree approximation.
// ----------------------------------------------------------------------------
package atd_pkg;

  localparam int COORD_W = 16;  // input coordinate width
  localparam int MAG_W   = 17;  // magnitudes up to 65536
  localparam int ANGLE_W = 9;   // result width, 0..360
  localparam int ANG_W   = 11;  // signed working width of the angle sum

  localparam int ANG_OFS_POS = 45;
  localparam int ANG_OFS_NEG = 135;
  localparam int COEF_LIN    = -56;
  localparam int COEF_CUB    = 11;
  localparam int ANG_HALF    = 180;
  localparam int ANG_FULL    = 360;

  // Sideband that travels with each item down the pipeline.
  typedef struct packed {
    logic y_zero;
    logic x_neg;
    logic y_neg;
    logic r_neg;
    logic r_full;  // |num| == den: ratio magnitude is exactly one (x zero or y zero)
  } atd_flags_t;

endpackage

// ----- hdl/atd_front.sv -----
// ----------------------------------------------------------------------------
// atd_front
// Input register stage: forms |num|, the divisor and the sign flags.
// ----------------------------------------------------------------------------
module atd_front
  import atd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s_valid,
  output logic                      s_ready,
  input  logic signed [COORD_W-1:0] s_y,
  input  logic signed [COORD_W-1:0] s_x,
  output logic                      m_valid,
  input  logic                      m_ready,
  output logic [MAG_W-1:0]          m_rem,
  output logic [MAG_W-1:0]          m_den,
  output atd_flags_t                m_flags
);

  logic              v_r;
  logic [MAG_W-1:0]  rem_r, rem_nxt;
  logic [MAG_W-1:0]  den_r, den_nxt;
  atd_flags_t        flags_r, flags_nxt;

  logic signed [MAG_W-1:0] y17, x17, ay;
  logic signed [MAG_W:0]   num, den_s, num_abs;

  assign s_ready = !v_r || m_ready;

  always_comb begin
    y17 = MAG_W'(s_y);
    x17 = MAG_W'(s_x);
    ay  = s_y[COORD_W-1] ? MAG_W'(-y17) : y17;
    if (!s_x[COORD_W-1]) begin
      num   = (MAG_W+1)'(x17) - (MAG_W+1)'(ay);
      den_s = (MAG_W+1)'(x17) + (MAG_W+1)'(ay);
    end else begin
      num   = (MAG_W+1)'(x17) + (MAG_W+1)'(ay);
      den_s = (MAG_W+1)'(ay) - (MAG_W+1)'(x17);
    end
    num_abs           = num[MAG_W] ? -num : num;
    flags_nxt.r_full  = (num_abs == den_s);
    // full-scale ratio is taken from the flag, not the divider, so its remainder starts at zero
    rem_nxt           = flags_nxt.r_full ? '0 : num_abs[MAG_W-1:0];
    den_nxt           = den_s[MAG_W-1:0];
    flags_nxt.y_zero  = (s_y == '0);
    flags_nxt.x_neg   = s_x[COORD_W-1];
    flags_nxt.y_neg   = s_y[COORD_W-1];
    flags_nxt.r_neg   = num[MAG_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (s_ready) begin
      v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      rem_r   <= rem_nxt;
      den_r   <= den_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign m_valid = v_r;
  assign m_rem   = rem_r;
  assign m_den   = den_r;
  assign m_flags = flags_r;

endmodule

// ----- hdl/atd_div_stage.sv -----
// ----------------------------------------------------------------------------
// atd_div_stage
// One restoring-division step: produces one quotient bit per stage.
// ----------------------------------------------------------------------------
module atd_div_stage
  import atd_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  logic [MAG_W-1:0]     s_rem,
  input  logic [MAG_W-1:0]     s_den,
  input  logic [FRAC_BITS-1:0] s_quo,
  input  atd_flags_t           s_flags,
  output logic                 m_valid,
  input  logic                 m_ready,
  output logic [MAG_W-1:0]     m_rem,
  output logic [MAG_W-1:0]     m_den,
  output logic [FRAC_BITS-1:0] m_quo,
  output atd_flags_t           m_flags
);

  logic                 v_r;
  logic [MAG_W-1:0]     rem_r, rem_nxt;
  logic [MAG_W-1:0]     den_r;
  logic [FRAC_BITS-1:0] quo_r, quo_nxt;
  atd_flags_t           flags_r;

  logic [MAG_W:0] rem_sh, diff;
  logic           ge;

  assign s_ready = !v_r || m_ready;

  // remainder stays below the divisor, so the shifted value fits MAG_W+1 bits
  always_comb begin
    rem_sh  = {s_rem, 1'b0};
    diff    = rem_sh - {1'b0, s_den};
    ge      = (rem_sh >= {1'b0, s_den});
    rem_nxt = ge ? diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
    quo_nxt = {s_quo[FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (s_ready) begin
      v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      rem_r   <= rem_nxt;
      den_r   <= s_den;
      quo_r   <= quo_nxt;
      flags_r <= s_flags;
    end
  end

  assign m_valid = v_r;
  assign m_rem   = rem_r;
  assign m_den   = den_r;
  assign m_quo   = quo_r;
  assign m_flags = flags_r;

endmodule

// ----- hdl/atd_poly.sv -----
// ----------------------------------------------------------------------------
// atd_poly
// Cubic polynomial in r, octant offset and mirroring; five register stages,
// the last one being the result register.
// ----------------------------------------------------------------------------
module atd_poly
  import atd_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  logic [FRAC_BITS-1:0] s_quo,
  input  atd_flags_t           s_flags,
  output logic                 m_valid,
  input  logic                 m_ready,
  output logic [ANGLE_W-1:0]   m_angle
);

  localparam int RW    = FRAC_BITS + 1;       // signed ratio
  localparam int PW    = 2 * FRAC_BITS + 2;   // signed products
  localparam int CW    = FRAC_BITS + 2;       // signed cube
  localparam int SUM_W = FRAC_BITS + 8;       // signed polynomial sum

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic ce1, ce2, ce3, ce4, ce5;

  logic signed [RW-1:0]    r1_r, r1_nxt, r2_r, r3_r;
  logic signed [PW-1:0]    sq2_r, cube3_r;
  logic signed [CW-1:0]    sqs;
  logic signed [CW-1:0]    r3v;
  logic signed [SUM_W-1:0] sum4_r, sum4_nxt;
  logic [ANGLE_W-1:0]      ang5_r, ang5_nxt;
  atd_flags_t              f1_r, f2_r, f3_r, f4_r;

  assign ce5     = !v5_r || m_ready;
  assign ce4     = !v4_r || ce5;
  assign ce3     = !v3_r || ce4;
  assign ce2     = !v2_r || ce3;
  assign ce1     = !v1_r || ce2;
  assign s_ready = ce1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (ce1) begin
        v1_r <= s_valid;
      end
      if (ce2) begin
        v2_r <= v1_r;
      end
      if (ce3) begin
        v3_r <= v2_r;
      end
      if (ce4) begin
        v4_r <= v3_r;
      end
      if (ce5) begin
        v5_r <= v4_r;
      end
    end
  end

  // stage 1: signed ratio, truncated toward zero; exactly -1.0 on the y axis
  always_comb begin
    if (s_flags.r_full) begin
      r1_nxt = $signed({1'b1, {FRAC_BITS{1'b0}}});
    end else if (s_flags.r_neg) begin
      r1_nxt = -$signed({1'b0, s_quo});
    end else begin
      r1_nxt = $signed({1'b0, s_quo});
    end
  end

  // stage 3 input: r^2 >> F is non-negative and at most 2^F
  assign sqs = $signed({1'b0, sq2_r[2*FRAC_BITS:FRAC_BITS]});

  // stage 4 input: floor shift of the cube product
  assign r3v = $signed(cube3_r[PW-1:FRAC_BITS]);

  always_comb begin
    sum4_nxt = SUM_W'(COEF_LIN) * SUM_W'(r3_r) + SUM_W'(COEF_CUB) * SUM_W'(r3v);
  end

  always_comb begin
    logic signed [SUM_W-1:0] poly_w;
    logic signed [ANG_W-1:0] ang;
    poly_w = sum4_r >>> FRAC_BITS;
    ang    = (f4_r.x_neg ? ANG_W'(ANG_OFS_NEG) : ANG_W'(ANG_OFS_POS)) + ANG_W'(poly_w);
    if (f4_r.y_neg) begin
      ang = ANG_W'(ANG_FULL) - ang;
    end
    if (f4_r.y_zero) begin
      ang = f4_r.x_neg ? ANG_W'(ANG_HALF) : '0;
    end
    ang5_nxt = ang[ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (s_valid && ce1) begin
      r1_r <= r1_nxt;
      f1_r <= s_flags;
    end
    if (v1_r && ce2) begin
      sq2_r <= r1_r * r1_r;
      r2_r  <= r1_r;
      f2_r  <= f1_r;
    end
    if (v2_r && ce3) begin
      cube3_r <= PW'(sqs * r2_r);
      r3_r    <= r2_r;
      f3_r    <= f2_r;
    end
    if (v3_r && ce4) begin
      sum4_r <= sum4_nxt;
      f4_r   <= f3_r;
    end
    if (v4_r && ce5) begin
      ang5_r <= ang5_nxt;
    end
  end

  assign m_valid = v5_r;
  assign m_angle = ang5_r;

endmodule

// ----- hdl/atan2_degrees_poly.sv -----
// ----------------------------------------------------------------------------
// atan2_degrees_poly
// Whole-degree angle (0..360) of a signed (y, x) pair, cubic approximation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one item: in_y_coord, in_x_coord.
//   Result channel out_valid/out_ready returns out_angle_deg, one per item,
//   in the order the items were taken.
//   The path is FRAC_BITS + 6 registers: one front register, FRAC_BITS
//   restoring-division stages (one quotient bit each) and five polynomial
//   stages ending in the result register.
//   Throughput is one item per cycle while out_ready stays high; the divider stages set the depth.
//   Every stage has its own valid bit and a local ready, so bubbles close up
//   and the block keeps accepting items while a result waits on out_ready.
//   When out_ready stays low the pipeline fills and in_ready then drops;
//   nothing is lost or repeated.
//   Synchronous reset (rst_n low) empties the pipeline; no other state kept.
// ----------------------------------------------------------------------------
module atan2_degrees_poly
  import atd_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic signed [COORD_W-1:0] in_x_coord,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ANGLE_W-1:0]        out_angle_deg
);

  logic                 dv    [FRAC_BITS+1];
  logic                 dr    [FRAC_BITS+1];
  logic [MAG_W-1:0]     drem  [FRAC_BITS+1];
  logic [MAG_W-1:0]     dden  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] dquo  [FRAC_BITS+1];
  atd_flags_t           dflg  [FRAC_BITS+1];

  atd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .s_y     (in_y_coord),
    .s_x     (in_x_coord),
    .m_valid (dv[0]),
    .m_ready (dr[0]),
    .m_rem   (drem[0]),
    .m_den   (dden[0]),
    .m_flags (dflg[0])
  );

  // quotient magnitude is below 2^FRAC_BITS since |num| < den; the
  // exceptions (x or y zero, ratio magnitude exactly one) are carried as a flag instead
  assign dquo[0] = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    atd_div_stage #(
      .FRAC_BITS (FRAC_BITS)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .s_valid (dv[i]),
      .s_ready (dr[i]),
      .s_rem   (drem[i]),
      .s_den   (dden[i]),
      .s_quo   (dquo[i]),
      .s_flags (dflg[i]),
      .m_valid (dv[i+1]),
      .m_ready (dr[i+1]),
      .m_rem   (drem[i+1]),
      .m_den   (dden[i+1]),
      .m_quo   (dquo[i+1]),
      .m_flags (dflg[i+1])
    );
  end

  atd_poly #(
    .FRAC_BITS (FRAC_BITS)
  ) u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (dv[FRAC_BITS]),
    .s_ready (dr[FRAC_BITS]),
    .s_quo   (dquo[FRAC_BITS]),
    .s_flags (dflg[FRAC_BITS]),
    .m_valid (out_valid),
    .m_ready (out_ready),
    .m_angle (out_angle_deg)
  );

endmodule

// ----- tb/tb_atan2_degrees_poly.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_atan2_degrees_poly
// Self-checking bench for the whole-degree atan2 approximation.
// A table of directed coordinate pairs covers the axes, the diagonals, the
// most negative inputs and the near-axis angles that wrap to 360. A long
// random run follows, with the sender and receiver idling in three mixes and
// one long output hold-off that backs the pipeline up into in_ready. Each result
// is checked against its table angle or a local fixed-point model of the curve.
// ----------------------------------------------------------------------------
module tb_atan2_degrees_poly;
  import atd_pkg::*;

  localparam int FRAC_BITS  = 8;
  localparam int LATENCY    = FRAC_BITS + 6;
  localparam int N_RAND     = 1450;
  localparam int HOLD_LEN   = 90;
  localparam int MAX_CYCLES = 200000;
  localparam int USE_MODEL  = -1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    int y;
    int x;
    int angle;  // USE_MODEL: take the angle from the model
  } dir_row_t;

  typedef struct {
    coord_t               y;
    coord_t               x;
    logic [ANGLE_W-1:0]   angle;
  } angle_exp_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  coord_t             in_y_coord;
  coord_t             in_x_coord;
  logic               out_valid;
  logic               out_ready;
  logic [ANGLE_W-1:0] out_angle_deg;

  angle_exp_t angle_q[$];
  int         err_count;
  int         items_sent;
  int         results_seen;
  int         in_stall_cycles;
  int         cycle_count;
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         hold_off_req;
  int         hold_cnt;

  dir_row_t dir_tab [24] = '{
    '{0,      0,      0},
    '{0,      32767,  0},
    '{0,      -1,     180},
    '{0,      -32768, 180},
    '{100,    100,    45},
    '{-100,   100,    315},
    '{100,    -100,   135},
    '{-100,   -100,   225},
    '{32767,  32767,  45},
    '{-32768, -32768, 225},
    '{-32768, 0,      270},
    '{32767,  0,      90},
    '{-1,     32767,  USE_MODEL},
    '{1,      32767,  USE_MODEL},
    '{32767,  -32768, USE_MODEL},
    '{-32768, 32767,  USE_MODEL},
    '{1,      -32768, USE_MODEL},
    '{-1,     -32768, USE_MODEL},
    '{32767,  -1,     USE_MODEL},
    '{-32768, -1,     USE_MODEL},
    '{-21846, 21845,  USE_MODEL},
    '{21845,  -21846, USE_MODEL},
    '{1,      0,      USE_MODEL},
    '{-1,     0,      USE_MODEL}
  };

  atan2_degrees_poly #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_y_coord   (in_y_coord),
    .in_x_coord   (in_x_coord),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_angle_deg(out_angle_deg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fixed-point angle curve: ratio, cube, polynomial, offset, mirror.
  function automatic logic [ANGLE_W-1:0] approx_angle(input coord_t y, input coord_t x);
    longint yl, xl, ay, num, den, r, r3, poly, ang;
    yl = y;
    xl = x;
    ay = (yl < 0) ? -yl : yl;
    if (yl == 0) begin
      ang = (xl >= 0) ? 0 : ANG_HALF;
    end else begin
      if (xl >= 0) begin
        num = xl - ay;
        den = xl + ay;
      end else begin
        num = xl + ay;
        den = ay - xl;
      end
      r    = (num * (longint'(1) << FRAC_BITS)) / den;  // truncates toward zero
      r3   = (((r * r) >>> FRAC_BITS) * r) >>> FRAC_BITS;
      poly = (COEF_LIN * r + COEF_CUB * r3) >>> FRAC_BITS;
      ang  = ((xl >= 0) ? ANG_OFS_POS : ANG_OFS_NEG) + poly;
      if (yl < 0) ang = ANG_FULL - ang;
    end
    return ang[ANGLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Drive one pair and hold it until the block takes it.
  task automatic send_pair(input coord_t y, input coord_t x, input int angle_override);
    angle_exp_t e;
    // each idle cycle is drawn on its own, so the idle share is send_idle_pct
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_y_coord <= y;
    in_x_coord <= x;
    do @(posedge clk); while (!in_ready);
    e.y = y;
    e.x = x;
    e.angle = (angle_override == USE_MODEL) ? approx_angle(y, x)
                                            : angle_override[ANGLE_W-1:0];
    angle_q.push_back(e);
    items_sent++;
  endtask

  function automatic coord_t pick_coord(input int mode);
    int pool [6] = '{-32768, -32767, -1, 0, 1, 32767};
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(32)) - 16);
      default: return coord_t'(pool[$urandom_range(5)]);
    endcase
  endfunction

  task automatic send_random;
    coord_t y, x;
    int     sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      y = pick_coord(0);
      x = pick_coord(0);
    end else if (sel < 55) begin
      y = pick_coord(1);
      x = pick_coord(1);
    end else if (sel < 65) begin
      y = '0;
      x = pick_coord($urandom_range(2));
    end else if (sel < 80) begin
      y = pick_coord($urandom_range(2));
      x = pick_coord($urandom_range(2));
    end else begin
      // near a diagonal: |y| close to |x|, any quadrant
      x = coord_t'($urandom_range(32000));
      y = x + coord_t'($signed($urandom_range(8)) - 4);
      if ($urandom_range(1)) x = -x;
      if ($urandom_range(1)) y = -y;
    end
    send_pair(y, x, USE_MODEL);
  endtask

  // Receiver: random back-pressure plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_cnt  = 0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_cnt     = HOLD_LEN - 1;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    angle_exp_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (angle_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result angle=%0d", out_angle_deg));
      end else begin
        e = angle_q.pop_front();
        if (out_angle_deg !== e.angle)
          report_mismatch($sformatf("y=%0d x=%0d: angle %0d, expected %0d",
                                    e.y, e.x, out_angle_deg, e.angle));
      end
    end
    if (rst_n && in_valid && !in_ready) in_stall_cycles++;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, angle_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_y_coord    = '0;
    in_x_coord    = '0;
    err_count     = 0;
    items_sent    = 0;
    results_seen  = 0;
    in_stall_cycles = 0;
    cycle_count   = 0;
    hold_off_req  = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 66;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_pair(coord_t'(dir_tab[i].y), coord_t'(dir_tab[i].x), dir_tab[i].angle);

    repeat (N_RAND / 3) send_random();

    send_idle_pct = 66;
    recv_idle_pct = 8;
    repeat (N_RAND / 3) send_random();

    // no idling; open with a long output stall so the pipeline backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 1'b1;
    repeat (N_RAND - 2 * (N_RAND / 3)) send_random();

    in_valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Sent %0d items, checked %0d angles; input stalled %0d cycles",
             items_sent, results_seen, in_stall_cycles);
    $display("Covered axes, diagonals, extreme coordinates and three idle mixes");
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
